/* rtl/pcsm_pkg.sv */
`timescale 1ns / 1ps

package pcsm_pkg;

  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int PHASE_BITS_DEF      = 32;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_BLACK_CODE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WHITE_CODE  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_SAMPLE = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_LINE   = 2'd3;

  localparam logic [15:0] BLACK_CODE_RESET  = 16'd16384;
  localparam logic [15:0] WHITE_CODE_RESET  = 16'd57344;
  localparam logic [31:0] STEP_SAMPLE_RESET = 32'd1073741824;
  localparam logic [31:0] STEP_LINE_RESET   = 32'd3228097420;

  // eight-field sequence: two fields per 625 lines, odd field starts 313 lines in
  // plus one for the half line
  localparam logic [11:0] LINES_PER_FIELD_PAIR = 12'd625;
  localparam logic [11:0] ODD_FIELD_START      = 12'd314;

  localparam logic signed [17:0] DIFF_OFFSET = 18'sd65535;
  localparam logic signed [31:0] U_GAIN      = 32'sd28574;
  localparam logic signed [32:0] V_GAIN      = 33'sd40303;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic [14:0] sin_mag;
    logic        sin_neg;
    logic [14:0] cos_mag;
    logic        cos_neg;
  } quad_sample_t;

  // quarter-wave sine entry, Q0.15, Taylor series in Q30
  function automatic logic [14:0] sine_entry(input int bits, input int i);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] s;
    logic signed [63:0] q;
    x    = (64'(i) * HALF_PI_Q30) >> bits;
    term = x;
    s    = $signed(x);
    for (int k = 1; k <= 9; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if ((k & 1) == 1) begin
        s = s - $signed(term);
      end else begin
        s = s + $signed(term);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    q = (s + 64'sd16384) >>> 15;
    if (q > 64'sd32767) begin
      q = 64'sd32767;
    end
    return q[14:0];
  endfunction

  // floor(a / 65535) estimate, low by at most one
  function automatic logic [18:0] div65535_est(input logic [33:0] a);
    logic [34:0] t;
    t = 35'(a) + 35'(a >> 16);
    return t[34:16];
  endfunction

  function automatic logic [18:0] div65535_fix(input logic [33:0] a, input logic [18:0] q0);
    logic [35:0] rem;
    rem = 36'(a) - (36'(q0) << 16) + 36'(q0);
    return (rem >= 36'd65535) ? q0 + 19'd1 : q0;
  endfunction

endpackage

/* rtl/pcsm_ifs.sv */
`timescale 1ns / 1ps

interface pcsm_pixel_if;
  logic        valid;
  logic        ready;
  logic [15:0] luma_in;
  logic [15:0] blue_diff_in;
  logic [15:0] red_diff_in;
  logic [10:0] sample_position;
  logic [8:0]  field_line;
  logic [2:0]  field_index;

  modport source (
    output valid, luma_in, blue_diff_in, red_diff_in, sample_position, field_line,
           field_index,
    input  ready
  );
  modport sink (
    input  valid, luma_in, blue_diff_in, red_diff_in, sample_position, field_line,
           field_index,
    output ready
  );
endinterface

interface pcsm_sample_if;
  logic        valid;
  logic        ready;
  logic [15:0] composite_out;

  modport source (
    output valid, composite_out,
    input  ready
  );
  modport sink (
    input  valid, composite_out,
    output ready
  );
endinterface

/* rtl/pcsm_quad_lut.sv */
`timescale 1ns / 1ps

module pcsm_quad_lut #(
  parameter int SINE_TABLE_BITS = pcsm_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [31:0]            phase,
  output pcsm_pkg::quad_sample_t lut
);
  import pcsm_pkg::*;

  localparam int N = 1 << SINE_TABLE_BITS;

  logic [14:0]              rom [N+1];
  logic [1:0]               quad;
  logic [1:0]               cquad;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [SINE_TABLE_BITS:0] top_addr;
  logic [SINE_TABLE_BITS:0] sin_addr;
  logic [SINE_TABLE_BITS:0] cos_addr;

  for (genvar i = 0; i <= N; i++) begin : g_rom
    localparam logic [14:0] ENTRY = sine_entry(SINE_TABLE_BITS, i);
    assign rom[i] = ENTRY;
  end

  assign top_addr = N[SINE_TABLE_BITS:0];
  assign quad     = phase[31:30];
  assign cquad    = quad + 2'd1;
  assign idx      = phase[29 -: SINE_TABLE_BITS];
  assign sin_addr = quad[0]  ? top_addr - {1'b0, idx} : {1'b0, idx};
  assign cos_addr = cquad[0] ? top_addr - {1'b0, idx} : {1'b0, idx};

  always_ff @(posedge clk) begin
    if (en) begin
      lut.sin_mag <= rom[sin_addr];
      lut.sin_neg <= quad[1];
      lut.cos_mag <= rom[cos_addr];
      lut.cos_neg <= cquad[1];
    end
  end

endmodule

/* rtl/pal_composite_sample_modulator_top.sv */
`timescale 1ns / 1ps

// PAL composite sample modulator. Each pixel transfer (Y, U, V, sample position, field
// line, field number mod 8) yields one saturated 16-bit composite sample: luma scaled
// between the black and white output codes plus U*sin + V-switched V*cos of the
// subcarrier phase, scaled by the same range. Fully pipelined: one pixel per clock
// sustained while the output accepts, passing through the 11 register stages
// (phase multiply, quarter-wave ROM read, chroma multiplies and the two divide-by-65535
// steps). Bubbles collapse and a stalled output holds back only the stages behind it.
// Configuration writes take effect at once and belong between items, with the pipeline
// empty.
module pal_composite_sample_modulator_top #(
  parameter int SINE_TABLE_BITS = pcsm_pkg::SINE_TABLE_BITS_DEF,
  parameter int PHASE_BITS      = pcsm_pkg::PHASE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [pcsm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pcsm_pkg::CFG_DATA_W-1:0]  cfg_data,
  pcsm_pixel_if.sink                      pixel,
  pcsm_sample_if.source                   sample
);
  import pcsm_pkg::*;

  localparam int NS = 11;

  logic [15:0] black_code;
  logic [15:0] white_code;
  logic [31:0] step_sample;
  logic [31:0] step_line;

  logic [NS:1]   vld;
  logic [NS+1:1] rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      black_code  <= BLACK_CODE_RESET;
      white_code  <= WHITE_CODE_RESET;
      step_sample <= STEP_SAMPLE_RESET;
      step_line   <= STEP_LINE_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_BLACK_CODE:  black_code  <= cfg_data[15:0];
        REG_WHITE_CODE:  white_code  <= cfg_data[15:0];
        REG_STEP_SAMPLE: step_sample <= cfg_data;
        REG_STEP_LINE:   step_line   <= cfg_data;
      endcase
    end
  end

  always_comb begin
    rdy[NS+1] = sample.ready;
    for (int k = NS; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= pixel.valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign pixel.ready = rdy[1];

  // stage registers
  logic [15:0]        s1_y;
  logic [10:0]        s1_pos;
  logic [11:0]        s1_n;
  logic signed [16:0] s1_ud;
  logic signed [16:0] s1_vd;
  logic [15:0]        s1_rmag;
  logic               s1_rneg;

  logic [31:0]        s2_ps;
  logic [31:0]        s2_pl;
  logic [31:0]        s2_ymag;
  logic signed [31:0] s2_udk;
  logic signed [32:0] s2_vdk;
  logic [15:0]        s2_rmag;
  logic               s2_rneg;

  logic [PHASE_BITS-1:0] s3_phase;
  logic [31:0]        s3_ymag;
  logic [18:0]        s3_yq0;
  logic signed [31:0] s3_udk;
  logic signed [32:0] s3_vdk;
  logic [15:0]        s3_rmag;
  logic               s3_rneg;

  quad_sample_t       lut;
  logic signed [17:0] s4_luma;
  logic signed [31:0] s4_udk;
  logic signed [32:0] s4_vdk;
  logic [15:0]        s4_rmag;
  logic               s4_rneg;

  logic signed [46:0] s5_pu;
  logic signed [47:0] s5_pv;
  logic               s5_sneg;
  logic               s5_cneg;
  logic signed [17:0] s5_luma;
  logic [15:0]        s5_rmag;
  logic               s5_rneg;

  logic signed [48:0] s6_sum;
  logic signed [17:0] s6_luma;
  logic [15:0]        s6_rmag;
  logic               s6_rneg;

  logic [31:0]        s7_tmag;
  logic               s7_cneg;
  logic signed [17:0] s7_luma;
  logic [15:0]        s7_rmag;

  logic [47:0]        s8_cm;
  logic               s8_cneg;
  logic signed [17:0] s8_luma;

  logic [33:0]        s9_ca;
  logic [18:0]        s9_cq0;
  logic               s9_cneg;
  logic signed [17:0] s9_luma;

  logic signed [17:0] s10_chroma;
  logic signed [17:0] s10_luma;

  logic [15:0]        s11_out;

  // combinational
  logic [11:0]        n_next;
  logic signed [16:0] rdiff;
  logic [15:0]        rmag_next;
  logic signed [16:0] ud_next;
  logic signed [16:0] vd_next;
  logic signed [16:0] vsel;
  logic [31:0]        phase_sum;
  logic [31:0]        phase_full;
  logic [18:0]        yq;
  logic signed [17:0] lum_base;
  logic signed [17:0] yq18;
  logic signed [48:0] pu49;
  logic signed [48:0] pv49;
  logic signed [48:0] term_u;
  logic signed [48:0] term_v;
  logic [47:0]        sabs;
  logic [18:0]        cq;
  logic signed [17:0] cq18;
  logic signed [18:0] comp;
  logic [15:0]        out_next;

  always_comb begin
    n_next = 12'(pixel.field_index[2:1]) * LINES_PER_FIELD_PAIR
           + (pixel.field_index[0] ? ODD_FIELD_START : 12'd0)
           + 12'(pixel.field_line);
    rdiff     = $signed({1'b0, white_code}) - $signed({1'b0, black_code});
    rmag_next = rdiff[16] ? 16'(-rdiff) : rdiff[15:0];
    ud_next   = 17'($signed({1'b0, pixel.blue_diff_in, 1'b0}) - DIFF_OFFSET);
    vd_next   = 17'($signed({1'b0, pixel.red_diff_in, 1'b0}) - DIFF_OFFSET);

    vsel      = s1_n[0] ? -s1_vd : s1_vd;

    phase_sum  = s2_ps + s2_pl;
    phase_full = 32'(s3_phase) << (32 - PHASE_BITS);

    yq       = div65535_fix(34'(s3_ymag), s3_yq0);
    lum_base = $signed({2'b00, black_code});
    yq18     = $signed(18'(yq));

    pu49   = 49'(s5_pu);
    pv49   = 49'(s5_pv);
    term_u = s5_sneg ? -pu49 : pu49;
    term_v = s5_cneg ? -pv49 : pv49;

    sabs = s6_sum[48] ? 48'(-s6_sum) : s6_sum[47:0];

    cq   = div65535_fix(s9_ca, s9_cq0);
    cq18 = $signed(18'(cq));

    comp = 19'(s10_luma) + 19'(s10_chroma);
    if (comp < 0) begin
      out_next = 16'd0;
    end else if (comp > 19'sd65535) begin
      out_next = 16'hFFFF;
    end else begin
      out_next = comp[15:0];
    end
  end

  pcsm_quad_lut #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_lut (
    .clk  (clk),
    .en   (rdy[4]),
    .phase(phase_full),
    .lut  (lut)
  );

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_y    <= pixel.luma_in;
      s1_pos  <= pixel.sample_position;
      s1_n    <= n_next;
      s1_ud   <= ud_next;
      s1_vd   <= vd_next;
      s1_rmag <= rmag_next;
      s1_rneg <= rdiff[16];
    end
    if (rdy[2]) begin
      s2_ps   <= 32'(s1_pos) * step_sample;
      s2_pl   <= 32'(s1_n) * step_line;
      s2_ymag <= 32'(s1_y) * 32'(s1_rmag);
      s2_udk  <= 32'(s1_ud) * U_GAIN;
      s2_vdk  <= 33'(vsel) * V_GAIN;
      s2_rmag <= s1_rmag;
      s2_rneg <= s1_rneg;
    end
    if (rdy[3]) begin
      s3_phase <= phase_sum[31 -: PHASE_BITS];
      s3_ymag  <= s2_ymag;
      s3_yq0   <= div65535_est(34'(s2_ymag));
      s3_udk   <= s2_udk;
      s3_vdk   <= s2_vdk;
      s3_rmag  <= s2_rmag;
      s3_rneg  <= s2_rneg;
    end
    if (rdy[4]) begin
      s4_luma <= s3_rneg ? lum_base - yq18 : lum_base + yq18;
      s4_udk  <= s3_udk;
      s4_vdk  <= s3_vdk;
      s4_rmag <= s3_rmag;
      s4_rneg <= s3_rneg;
    end
    if (rdy[5]) begin
      s5_pu   <= 47'(s4_udk) * $signed(47'(lut.sin_mag));
      s5_pv   <= 48'(s4_vdk) * $signed(48'(lut.cos_mag));
      s5_sneg <= lut.sin_neg;
      s5_cneg <= lut.cos_neg;
      s5_luma <= s4_luma;
      s5_rmag <= s4_rmag;
      s5_rneg <= s4_rneg;
    end
    if (rdy[6]) begin
      s6_sum  <= term_u + term_v;
      s6_luma <= s5_luma;
      s6_rmag <= s5_rmag;
      s6_rneg <= s5_rneg;
    end
    if (rdy[7]) begin
      s7_tmag <= sabs[47:16];
      s7_cneg <= s6_sum[48] ^ s6_rneg;
      s7_luma <= s6_luma;
      s7_rmag <= s6_rmag;
    end
    if (rdy[8]) begin
      s8_cm   <= 48'(s7_tmag) * 48'(s7_rmag);
      s8_cneg <= s7_cneg;
      s8_luma <= s7_luma;
    end
    if (rdy[9]) begin
      s9_ca   <= 34'(s8_cm[47:15]);
      s9_cq0  <= div65535_est(34'(s8_cm[47:15]));
      s9_cneg <= s8_cneg;
      s9_luma <= s8_luma;
    end
    if (rdy[10]) begin
      s10_chroma <= s9_cneg ? -cq18 : cq18;
      s10_luma   <= s9_luma;
    end
    if (rdy[11]) begin
      s11_out <= out_next;
    end
  end

  assign sample.valid         = vld[NS];
  assign sample.composite_out = s11_out;

endmodule

/* bench/pal_composite_sample_modulator_top_tb.sv */
`timescale 1ns / 1ps

module pal_composite_sample_modulator_top_tb;
  import pcsm_pkg::*;

  localparam int SINE_BITS   = SINE_TABLE_BITS_DEF;
  localparam int QTR_N       = 1 << SINE_BITS;
  localparam int LATENCY     = 11;
  localparam int CYCLE_LIMIT = 600000;
  localparam longint U_COEF  = 28574;
  localparam longint V_COEF  = 40303;

  typedef struct {
    logic [15:0] luma;
    logic [15:0] u;
    logic [15:0] v;
    logic [10:0] pos;
    logic [8:0]  line;
    logic [2:0]  field;
  } pixel_t;

  logic clk;
  logic rst;
  logic cfg_wen;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pcsm_pixel_if  pix ();
  pcsm_sample_if smp ();

  pal_composite_sample_modulator_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pix),
    .sample    (smp)
  );

  logic [15:0] blk_level;
  logic [15:0] wht_level;
  logic [31:0] step_sample;
  logic [31:0] step_line;
  int          quarter_sine [0:QTR_N];

  logic [15:0] composite_queue [$];
  logic [15:0] expected_sample;
  int          errors;
  int          cycles;
  int          sink_wait;
  bit          src_idle;
  bit          snk_idle;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void build_quarter_sine();
    bit [63:0] x;
    bit [63:0] term;
    longint    s;
    longint    q;
    for (int i = 0; i <= QTR_N; i++) begin
      x    = (64'(i) * 64'd1686629713) >> SINE_BITS;
      term = x;
      s    = longint'(x);
      for (int k = 1; k <= 9; k++) begin
        term = (((term * x) >> 30) * x) >> 30;
        term = term / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          s = s - longint'(term);
        end else begin
          s = s + longint'(term);
        end
      end
      if (s < 0) s = 0;
      q = (s + 16384) / 32768;
      if (q > 32767) q = 32767;
      quarter_sine[i] = int'(q);
    end
  endfunction

  function automatic longint subcarrier_sine(logic [31:0] ph);
    int idx;
    int mag;
    idx = int'(ph[29 -: SINE_BITS]);
    mag = ph[30] ? quarter_sine[QTR_N - idx] : quarter_sine[idx];
    return ph[31] ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic [15:0] predict_composite(pixel_t p);
    int          n;
    logic [31:0] ph;
    longint      rng, luma, sn, cs, ud, vd, sum, t, chroma, comp;
    n  = int'(p.field >> 1) * 625 + (p.field[0] ? 314 : 0) + int'(p.line);
    ph = 32'(longint'(p.pos) * longint'(step_sample) + longint'(n) * longint'(step_line));
    ph = ph & ~((32'd1 << (32 - PHASE_BITS_DEF)) - 32'd1);
    sn = subcarrier_sine(ph);
    cs = subcarrier_sine(ph + 32'h4000_0000);
    rng  = longint'(wht_level) - longint'(blk_level);
    luma = longint'(blk_level) + (longint'(p.luma) * rng) / 65535;
    ud = 2 * longint'(p.u) - 65535;
    vd = 2 * longint'(p.v) - 65535;
    if (n % 2 == 1) vd = -vd;
    sum    = ud * U_COEF * sn + vd * V_COEF * cs;
    t      = sum / 65536;
    chroma = (t * rng) / (longint'(65535) * 32768);
    comp   = luma + chroma;
    if (comp < 0) comp = 0;
    if (comp > 65535) comp = 65535;
    return comp[15:0];
  endfunction

  function automatic pixel_t pixel_of(int l, int u, int v, int pos, int line, int fld);
    pixel_t p;
    p.luma  = 16'(l);
    p.u     = 16'(u);
    p.v     = 16'(v);
    p.pos   = 11'(pos);
    p.line  = 9'(line);
    p.field = 3'(fld);
    return p;
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return STEP_LINE_RESET;
      default: return $urandom;
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.luma  = pick16();
    p.u     = pick16();
    p.v     = pick16();
    p.pos   = 11'($urandom_range(0, 2047));
    p.line  = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(313, 511))
                                          : 9'($urandom_range(0, 312));
    p.field = 3'($urandom_range(0, 7));
    return p;
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_wen   = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_wen = 1'b0;
    case (idx)
      REG_BLACK_CODE:  blk_level = data[15:0];
      REG_WHITE_CODE:  wht_level = data[15:0];
      REG_STEP_SAMPLE: step_sample = data;
      REG_STEP_LINE:   step_line = data;
      default: ;
    endcase
  endtask

  // upper bits of the level writes carry junk that the block must drop
  task automatic apply_config(input logic [15:0] b, input logic [15:0] w,
                              input logic [31:0] ss, input logic [31:0] sl);
    write_reg(REG_BLACK_CODE, {16'($urandom), b});
    write_reg(REG_WHITE_CODE, {16'($urandom), w});
    write_reg(REG_STEP_SAMPLE, ss);
    write_reg(REG_STEP_LINE, sl);
  endtask

  task automatic send_pixel(input pixel_t p);
    int gap;
    gap = src_idle ? $urandom_range(0, 11) : 0;
    repeat (gap) begin
      @(negedge clk);
      pix.valid = 1'b0;
    end
    @(negedge clk);
    pix.valid           = 1'b1;
    pix.luma_in         = p.luma;
    pix.blue_diff_in    = p.u;
    pix.red_diff_in     = p.v;
    pix.sample_position = p.pos;
    pix.field_line      = p.line;
    pix.field_index     = p.field;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    composite_queue.push_back(predict_composite(p));
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    pix.valid = 1'b0;
    while (composite_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic test_reset_extremes();
    src_idle = 1'b0;
    snk_idle = 1'b0;
    send_pixel(pixel_of(0, 32768, 32768, 0, 0, 0));
    send_pixel(pixel_of(65535, 32768, 32768, 0, 0, 0));
    send_pixel(pixel_of(32768, 65535, 32768, 1, 0, 0));
    send_pixel(pixel_of(32768, 0, 32768, 2, 0, 0));
    send_pixel(pixel_of(32768, 32768, 65535, 3, 1, 0));
    send_pixel(pixel_of(32768, 32768, 0, 3, 1, 1));
    send_pixel(pixel_of(65535, 65535, 65535, 2047, 312, 7));
    send_pixel(pixel_of(0, 0, 0, 2047, 511, 6));
    for (int f = 0; f < 8; f++) begin
      send_pixel(pixel_of(49152, 65535, 0, f * 256 + 5, f * 40, f));
    end
    drain_pipeline();
  endtask

  task automatic test_level_step_extremes();
    src_idle = 1'b1;
    snk_idle = 1'b1;
    // black above white inverts luma and chroma
    apply_config(16'hffff, 16'h0000, STEP_SAMPLE_RESET, STEP_LINE_RESET);
    send_pixel(pixel_of(65535, 0, 65535, 7, 100, 3));
    send_pixel(pixel_of(0, 65535, 0, 9, 101, 2));
    drain_pipeline();
    apply_config(16'd30000, 16'd30000, STEP_SAMPLE_RESET, STEP_LINE_RESET);
    send_pixel(pixel_of(65535, 65535, 65535, 11, 7, 5));
    drain_pipeline();
    apply_config(16'h0000, 16'hffff, 32'h0, 32'h0);
    send_pixel(pixel_of(0, 32768, 65535, 2047, 312, 7));
    send_pixel(pixel_of(65535, 65535, 0, 1024, 0, 1));
    drain_pipeline();
    apply_config(16'h0000, 16'hffff, 32'hffff_ffff, 32'hffff_ffff);
    send_pixel(pixel_of(32768, 0, 0, 2047, 511, 7));
    send_pixel(pixel_of(32768, 65535, 65535, 1, 313, 0));
    drain_pipeline();
  endtask

  task automatic test_config_sweep();
    for (int ph = 0; ph < 10; ph++) begin
      apply_config(pick16(), pick16(), pick_step(), pick_step());
      for (int i = 0; i < 120; i++) begin
        if (i % 40 == 0) begin
          src_idle = $urandom_range(0, 2) != 0;
          snk_idle = $urandom_range(0, 2) != 0;
        end
        send_pixel(random_pixel());
      end
      drain_pipeline();
    end
  endtask

  task automatic test_stream_with_pause();
    apply_config(BLACK_CODE_RESET, WHITE_CODE_RESET, STEP_SAMPLE_RESET, STEP_LINE_RESET);
    for (int i = 0; i < 550; i++) begin
      if (i % 50 == 0) begin
        src_idle = $urandom_range(0, 1);
        snk_idle = $urandom_range(0, 1);
      end
      // hold the source until every outstanding sample has come back
      if (i == 275) drain_pipeline();
      send_pixel(random_pixel());
    end
    drain_pipeline();
  endtask

  always @(negedge clk) begin
    if (sink_wait > 0) begin
      smp.ready = 1'b0;
      sink_wait--;
    end else begin
      smp.ready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && smp.valid && smp.ready) begin
      if (composite_queue.size() == 0) begin
        errors++;
        $display("%0t: composite transfer with none expected, actual %h", $time,
                 smp.composite_out);
      end else begin
        expected_sample = composite_queue.pop_front();
        if (smp.composite_out !== expected_sample) begin
          errors++;
          $display("%0t: composite_out mismatch: expected %h, actual %h", $time,
                   expected_sample, smp.composite_out);
        end
      end
      sink_wait = snk_idle ? $urandom_range(0, 11) : 0;
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** pal_composite_sample_modulator_top: FAILED **");
    $finish;
  end

  initial begin
    rst                 = 1'b1;
    cfg_wen             = 1'b0;
    cfg_index           = REG_BLACK_CODE;
    cfg_data            = '0;
    pix.valid           = 1'b0;
    pix.luma_in         = '0;
    pix.blue_diff_in    = '0;
    pix.red_diff_in     = '0;
    pix.sample_position = '0;
    pix.field_line      = '0;
    pix.field_index     = '0;
    smp.ready           = 1'b0;
    sink_wait           = 0;
    errors              = 0;
    src_idle            = 1'b0;
    snk_idle            = 1'b0;
    blk_level           = BLACK_CODE_RESET;
    wht_level           = WHITE_CODE_RESET;
    step_sample         = STEP_SAMPLE_RESET;
    step_line           = STEP_LINE_RESET;
    build_quarter_sine();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_extremes();
    test_level_step_extremes();
    test_config_sweep();
    test_stream_with_pause();

    if (errors == 0) begin
      $display("** pal_composite_sample_modulator_top: PASSED **");
    end else begin
      $display("** pal_composite_sample_modulator_top: FAILED **");
    end
    $finish;
  end

endmodule
